### hw/rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table package
// Shared types, codes and constants for the linear probing key table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int KEY_BITS     = 31;
	localparam int CAPACITY_DEF = 1024;
	localparam int INIT_SIZE_W  = 11;
	localparam int THR_W        = 4;
	localparam int SLOT_W       = 10;
	localparam int COUNT_W      = 11;
	localparam int CFG_IDX_W    = 2;

	localparam logic [INIT_SIZE_W-1:0] INIT_SIZE_RST = 11'd5;
	localparam logic [THR_W-1:0]       THR_RST       = 4'd7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_USED  = 2'd1,
		TAG_TOMB  = 2'd2
	} tag_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT_SIZE = 2'd0,
		REG_THRESHOLD = 2'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_SWEEP, ST_IDLE, ST_HOME, ST_RD, ST_CHK, ST_INS_WR, ST_GROW,
		ST_RB_RD, ST_RB_CHK, ST_RB_HOME, ST_RB_PRD, ST_RB_PCHK, ST_CLEAR, ST_DONE
	} state_t;

	typedef struct packed {
		op_t                 operation;
		logic [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] key_total;
		logic [COUNT_W-1:0] size_in_use;
		logic               grew;
	} rsp_t;

endpackage

### hw/rtl/linear_probing_hash_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table core
// Key table with insert, search, delete and clear, tombstone deletion and
// growth by rebuild into a second bank.
// ----------------------------------------------------------------------------
// The block handles one operation at a time and is not ready while it works.
// After reset it sweeps all 2*CAPACITY slots to empty before the first beat
// is accepted; configuration beats are taken throughout. Insert, search and
// delete first reduce the key modulo the size in use on a shared bit-serial
// modulo unit (an insert into a full table goes straight to its result), then
// probe the slot memory one slot at a time, since each read is registered
// before it is examined. Insert then writes the slot and runs the growth
// test. A growing insert then walks every slot of the old bank and, for every
// held key, reduces it modulo the new size to its new home and probes the new
// bank from there for an empty slot. Clear empties each slot of the size in
// use in turn. The result beat is then presented, and waits in its own
// register until it is taken.
// ----------------------------------------------------------------------------
module linear_probing_hash_table_core
	import lpht_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  req_t                   req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rsp_t                   rsp,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [INIT_SIZE_W-1:0] cfg_data
);

	// Slot index, size and memory address widths all follow from the capacity.
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int SZ_W  = $clog2(CAPACITY + 1);
	localparam int DEPTH = 2 * CAPACITY;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = KEY_BITS + 2;
	localparam int CMP_W = (SZ_W > INIT_SIZE_W) ? SZ_W : INIT_SIZE_W;
	localparam int GR_W  = SZ_W + THR_W;

	state_t state_q, state_d;

	logic                   bank_q;
	logic [SZ_W-1:0]        held_q;
	logic [SZ_W-1:0]        size_q;
	logic [INIT_SIZE_W-1:0] init_q;
	logic [THR_W-1:0]       thr_q;
	logic [AW-1:0]          sweep_q;
	op_t                    op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [KEY_BITS-1:0]    rkey_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       ri_q;
	logic [IDX_W-1:0]       track_q;
	logic [SZ_W-1:0]        cnt_q;
	status_t                status_q;
	logic [IDX_W-1:0]       slot_q;
	logic                   grew_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   mod_start;
	logic [KEY_BITS-1:0]    mod_dvd;
	logic [SZ_W-1:0]        mod_div;
	logic                   mod_done;
	logic [SZ_W-1:0]        mod_rem;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [DW-1:0]          ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [DW-1:0]          ram_rdata;

	tag_t                   rd_tag;
	logic [KEY_BITS-1:0]    rd_key;
	logic                   accept;
	logic                   full;
	logic                   hit;
	logic                   probe_last;
	logic                   rb_last;
	logic                   sweep_last;
	logic                   grow;
	logic [SZ_W-1:0]        new_size;
	logic [SZ_W-1:0]        wrap_size;
	logic [IDX_W-1:0]       idx_next;
	logic [SZ_W-1:0]        start_size;
	logic [CMP_W-1:0]       init_ext;
	logic [GR_W-1:0]        load_lhs;
	logic [GR_W-1:0]        load_rhs;

	function automatic logic [AW-1:0] slot_addr(input logic b, input logic [IDX_W-1:0] i);
		logic [AW-1:0] base;
		base = b ? AW'(CAPACITY) : '0;
		return base + AW'(i);
	endfunction

	lpht_mod_unit #(
		.SZ_W(SZ_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (mod_div),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	lpht_slot_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (DW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rd_tag = tag_t'(ram_rdata[DW-1:KEY_BITS]);
	assign rd_key = ram_rdata[KEY_BITS-1:0];

	// A table counts as full only when every slot holds a live key; tombstones
	// are free for reuse by an insert.
	assign full       = (held_q >= size_q);
	assign hit        = (rd_tag == TAG_USED) && (rd_key == key_q);
	assign probe_last = (cnt_q == size_q - SZ_W'(1));
	assign rb_last    = (SZ_W'(ri_q) == size_q - SZ_W'(1));
	assign sweep_last = (sweep_q == AW'(DEPTH - 1));

	// The rebuilt size is 2s+1; it is only taken when it fits the capacity.
	assign new_size  = SZ_W'({size_q, 1'b1});
	assign wrap_size = (state_q == ST_RB_PCHK) ? new_size : size_q;
	assign idx_next  = (SZ_W'(idx_q) == wrap_size - SZ_W'(1)) ? '0 : idx_q + 1'b1;

	// Growth is tested as held*10 >= threshold*size in integer arithmetic.
	assign load_lhs = GR_W'(held_q) * GR_W'(10);
	assign load_rhs = GR_W'(thr_q) * GR_W'(size_q);
	assign grow     = (load_lhs >= load_rhs) &&
	                  (({1'b0, size_q, 1'b1}) <= (SZ_W + 2)'(CAPACITY));

	// A zero start size is taken as one, and one beyond the capacity is clipped.
	assign init_ext = CMP_W'(init_q);
	always_comb begin
		if (init_ext == '0) begin
			start_size = SZ_W'(1);
		end else if (init_ext > CMP_W'(CAPACITY)) begin
			start_size = SZ_W'(CAPACITY);
		end else begin
			start_size = SZ_W'(init_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory port control and modulo unit start.
	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		mod_dvd   = req.key;
		mod_div   = size_q;
		ram_re    = 1'b0;
		ram_raddr = slot_addr(bank_q, idx_q);
		ram_we    = 1'b0;
		ram_waddr = slot_addr(bank_q, idx_q);
		ram_wdata = {TAG_EMPTY, key_q};
		case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.operation)
						OP_CLEAR: begin
							state_d = ST_CLEAR;
						end
						OP_INSERT: begin
							if (full) begin
								state_d = ST_DONE;
							end else begin
								mod_start = 1'b1;
								state_d   = ST_HOME;
							end
						end
						default: begin
							mod_start = 1'b1;
							state_d   = ST_HOME;
						end
					endcase
				end
			end
			ST_HOME: begin
				if (mod_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (op_q == OP_INSERT) begin
					state_d = (rd_tag == TAG_USED) ? ST_RD : ST_INS_WR;
				end else if (rd_tag == TAG_EMPTY) begin
					state_d = ST_DONE;
				end else if (hit) begin
					if (op_q == OP_DELETE) begin
						ram_we    = 1'b1;
						ram_wdata = {TAG_TOMB, key_q};
					end
					state_d = ST_DONE;
				end else if (probe_last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_INS_WR: begin
				ram_we    = 1'b1;
				ram_wdata = {TAG_USED, key_q};
				state_d   = ST_GROW;
			end
			ST_GROW: begin
				state_d = grow ? ST_RB_RD : ST_DONE;
			end
			ST_RB_RD: begin
				ram_re    = 1'b1;
				ram_raddr = slot_addr(bank_q, ri_q);
				state_d   = ST_RB_CHK;
			end
			ST_RB_CHK: begin
				// The old slot is emptied as soon as it has been read.
				ram_we    = 1'b1;
				ram_waddr = slot_addr(bank_q, ri_q);
				if (rd_tag == TAG_USED) begin
					mod_start = 1'b1;
					mod_dvd   = rd_key;
					mod_div   = new_size;
					state_d   = ST_RB_HOME;
				end else begin
					state_d = rb_last ? ST_DONE : ST_RB_RD;
				end
			end
			ST_RB_HOME: begin
				if (mod_done) begin
					state_d = ST_RB_PRD;
				end
			end
			ST_RB_PRD: begin
				ram_re    = 1'b1;
				ram_raddr = slot_addr(!bank_q, idx_q);
				state_d   = ST_RB_PCHK;
			end
			ST_RB_PCHK: begin
				if (rd_tag != TAG_EMPTY) begin
					state_d = ST_RB_PRD;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = slot_addr(!bank_q, idx_q);
					ram_wdata = {TAG_USED, rkey_q};
					state_d   = rb_last ? ST_DONE : ST_RB_RD;
				end
			end
			ST_CLEAR: begin
				// Only the live bank can hold tags; the other is always empty.
				ram_we    = 1'b1;
				ram_waddr = slot_addr(bank_q, ri_q);
				if (rb_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			held_q      <= '0;
			size_q      <= SZ_W'(INIT_SIZE_RST);
			init_q      <= INIT_SIZE_RST;
			thr_q       <= THR_RST;
			sweep_q     <= '0;
			op_q        <= OP_INSERT;
			key_q       <= '0;
			rkey_q      <= '0;
			idx_q       <= '0;
			ri_q        <= '0;
			track_q     <= '0;
			cnt_q       <= '0;
			status_q    <= STAT_OK;
			slot_q      <= '0;
			grew_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INIT_SIZE: init_q <= cfg_data;
					REG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			// In the done state the result register is reloaded whenever it is
			// taken, so the beat is only retired here outside that state.
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						op_q     <= req.operation;
						key_q    <= req.key;
						cnt_q    <= '0;
						ri_q     <= '0;
						slot_q   <= '0;
						grew_q   <= 1'b0;
						status_q <= (req.operation == OP_INSERT && full) ? STAT_FULL : STAT_OK;
					end
				end
				ST_HOME, ST_RB_HOME: begin
					if (mod_done) begin
						idx_q <= IDX_W'(mod_rem);
					end
				end
				ST_CHK: begin
					if (op_q == OP_INSERT) begin
						if (rd_tag == TAG_USED) begin
							idx_q <= idx_next;
						end
					end else if (rd_tag == TAG_EMPTY) begin
						status_q <= STAT_MISS;
					end else if (hit) begin
						slot_q <= idx_q;
						if (op_q == OP_DELETE && held_q != '0) begin
							held_q <= held_q - 1'b1;
						end
					end else if (probe_last) begin
						status_q <= STAT_MISS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						idx_q <= idx_next;
					end
				end
				ST_INS_WR: begin
					held_q <= held_q + 1'b1;
					slot_q <= idx_q;
				end
				ST_GROW: begin
					if (grow) begin
						track_q <= idx_q;
						grew_q  <= 1'b1;
						ri_q    <= '0;
					end
				end
				ST_RB_CHK: begin
					if (rd_tag == TAG_USED) begin
						rkey_q <= rd_key;
					end else if (rb_last) begin
						bank_q <= !bank_q;
						size_q <= new_size;
					end else begin
						ri_q <= ri_q + 1'b1;
					end
				end
				ST_RB_PCHK: begin
					if (rd_tag != TAG_EMPTY) begin
						idx_q <= idx_next;
					end else begin
						// The inserted key is followed to its new slot.
						if (ri_q == track_q) begin
							slot_q <= idx_q;
						end
						if (rb_last) begin
							bank_q <= !bank_q;
							size_q <= new_size;
						end else begin
							ri_q <= ri_q + 1'b1;
						end
					end
				end
				ST_CLEAR: begin
					if (rb_last) begin
						bank_q <= 1'b0;
						held_q <= '0;
						size_q <= start_size;
					end else begin
						ri_q <= ri_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.status      <= status_q;
						rsp_q.slot        <= SLOT_W'(slot_q);
						rsp_q.key_total   <= COUNT_W'(held_q);
						rsp_q.size_in_use <= COUNT_W'(size_q);
						rsp_q.grew        <= grew_q;
					end
				end
				default: ;
			endcase
		end
	end

	// The live key count can never exceed the size in use.
	a_held_within_size: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= size_q)
		else $error("held key count exceeds size in use");

	// The size in use never passes the capacity.
	a_size_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		SZ_W'(size_q) <= SZ_W'(CAPACITY) && size_q != '0)
		else $error("size in use outside its range");

	// The sequencer never reads and writes one slot in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("slot memory read and write to the same address");

	// A rebuild is only reported for a successful insert.
	a_grew_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.grew |-> rsp.status == STAT_OK)
		else $error("rebuild reported on a failed operation");

	// The modulo result is taken exactly when the home phase ends.
	a_home_to_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOME && mod_done) |=> state_q == ST_RD)
		else $error("home slot phase did not lead to a probe");

endmodule

### hw/rtl/lpht_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative modulo unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lpht_mod_unit
	import lpht_pkg::*;
#(
	parameter int SZ_W = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] dividend,
	input  logic [SZ_W-1:0]     divisor,
	output logic                done,
	output logic [SZ_W-1:0]     remainder
);

	localparam int CNT_W = $clog2(KEY_BITS + 1);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [KEY_BITS-1:0] dvd_q;
	logic [SZ_W-1:0]     div_q;
	logic [SZ_W-1:0]     rem_q;
	logic [SZ_W:0]       trial;
	logic [SZ_W:0]       step;

	always_comb begin
		trial = {rem_q, dvd_q[KEY_BITS-1]};
		if (trial >= {1'b0, div_q}) begin
			step = trial - {1'b0, div_q};
		end else begin
			step = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(KEY_BITS);
			dvd_q  <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				rem_q <= step[SZ_W-1:0];
				dvd_q <= {dvd_q[KEY_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign done      = busy_q && (cnt_q == '0);
	assign remainder = rem_q;

endmodule

### hw/rtl/lpht_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one registered read port holding tag and key per slot.
// ----------------------------------------------------------------------------
module lpht_slot_ram
	import lpht_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 33
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table core testbench
// Drives insert, search, delete and clear beats into the core, predicts every
// response from an internal table model with its own banks, tags and sizes,
// and compares each response field by field. Configuration is changed only
// while the core is idle, and both handshakes are idled and stalled at random.
// ----------------------------------------------------------------------------
module tb;
	import lpht_pkg::*;

	localparam int          CAP        = CAPACITY_DEF;
	localparam int          TAB_DEPTH  = 2 * CAP;
	// Indexes beyond the two registers; writes to them must change nothing.
	localparam logic [1:0]  REG_SPARE_A = 2'd2;
	localparam logic [1:0]  REG_SPARE_B = 2'd3;
	localparam logic [30:0] KEY_MAX     = 31'h7FFF_FFFF;

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_ready;
	req_t                   req;
	logic                   rsp_valid;
	logic                   rsp_ready;
	rsp_t                   rsp;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [INIT_SIZE_W-1:0] cfg_data;

	linear_probing_hash_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the key table: two banks of keys and occupancy tags.
	logic [KEY_BITS-1:0] shadow_keys [TAB_DEPTH];
	tag_t                shadow_tags [TAB_DEPTH];
	int                  shadow_bank;
	int                  shadow_count;
	int                  shadow_size;
	logic [10:0]         shadow_init_size;
	logic [3:0]          shadow_thr;

	rsp_t                pending_rsp_q[$];
	logic [KEY_BITS-1:0] key_pool[$];

	int  mismatch_count;
	int  rsp_count;
	int  beat_count;
	int  grow_count;
	int  full_count;
	bit  gaps_on;
	bit  hold_request;
	int  hold_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Timeout with %0d responses still outstanding", pending_rsp_q.size());
		$display("Mismatches found");
		$finish;
	end

	// Size in use after a clear: zero is taken as one, and anything above the
	// capacity is clamped to it.
	function automatic int clear_size();
		if (shadow_init_size == 0)
			return 1;
		if (shadow_init_size > CAP)
			return CAP;
		return int'(shadow_init_size);
	endfunction

	function automatic int home_slot(logic [KEY_BITS-1:0] key, int size);
		longint unsigned k;
		k = key;
		return int'(k % longint'(size));
	endfunction

	// Search for the first occupied copy of a key, skipping tombstones and
	// stopping at an empty slot or after a full lap of the table.
	function automatic bit find_key(logic [KEY_BITS-1:0] key, output int where);
		int base;
		int idx;
		base  = shadow_bank * CAP;
		idx   = home_slot(key, shadow_size);
		where = 0;
		for (int n = 0; n < shadow_size; n++) begin
			if (shadow_tags[base + idx] == TAG_EMPTY)
				return 1'b0;
			if (shadow_tags[base + idx] == TAG_USED && shadow_keys[base + idx] == key) begin
				where = idx;
				return 1'b1;
			end
			idx = (idx + 1 >= shadow_size) ? 0 : idx + 1;
		end
		return 1'b0;
	endfunction

	// Move every held key into the other bank at size 2s+1, in slot order,
	// dropping tombstones. Returns where the key from old slot 'track' lands.
	function automatic int regrow_table(int track);
		int old_base;
		int new_base;
		int new_size;
		int idx;
		int landed;
		old_base = shadow_bank * CAP;
		new_base = (shadow_bank ^ 1) * CAP;
		new_size = 2 * shadow_size + 1;
		landed   = 0;
		for (int i = 0; i < CAP; i++)
			shadow_tags[new_base + i] = TAG_EMPTY;
		for (int i = 0; i < shadow_size; i++) begin
			if (shadow_tags[old_base + i] == TAG_USED) begin
				idx = home_slot(shadow_keys[old_base + i], new_size);
				while (shadow_tags[new_base + idx] != TAG_EMPTY)
					idx = (idx + 1 >= new_size) ? 0 : idx + 1;
				shadow_tags[new_base + idx] = TAG_USED;
				shadow_keys[new_base + idx] = shadow_keys[old_base + i];
				if (i == track)
					landed = idx;
			end
		end
		for (int i = 0; i < CAP; i++)
			shadow_tags[old_base + i] = TAG_EMPTY;
		shadow_bank = shadow_bank ^ 1;
		shadow_size = new_size;
		return landed;
	endfunction

	// Apply one operation to the shadow table and return the response it owes.
	function automatic rsp_t table_outcome(op_t op, logic [KEY_BITS-1:0] key);
		rsp_t r;
		int   base;
		int   idx;
		int   where;
		r = '{status: STAT_OK, slot: '0, key_total: '0, size_in_use: '0, grew: 1'b0};
		base = shadow_bank * CAP;
		case (op)
			OP_INSERT: begin
				if (shadow_count >= shadow_size) begin
					r.status = STAT_FULL;
				end else begin
					idx = home_slot(key, shadow_size);
					while (shadow_tags[base + idx] == TAG_USED)
						idx = (idx + 1 >= shadow_size) ? 0 : idx + 1;
					shadow_tags[base + idx] = TAG_USED;
					shadow_keys[base + idx] = key;
					shadow_count++;
					r.slot = idx[SLOT_W-1:0];
					if (shadow_count * 10 >= int'(shadow_thr) * shadow_size &&
						2 * shadow_size + 1 <= CAP) begin
						idx    = regrow_table(idx);
						r.slot = idx[SLOT_W-1:0];
						r.grew = 1'b1;
					end
				end
			end
			OP_SEARCH: begin
				if (find_key(key, where))
					r.slot = where[SLOT_W-1:0];
				else
					r.status = STAT_MISS;
			end
			OP_DELETE: begin
				if (find_key(key, where)) begin
					shadow_tags[base + where] = TAG_TOMB;
					if (shadow_count > 0)
						shadow_count--;
					r.slot = where[SLOT_W-1:0];
				end else begin
					r.status = STAT_MISS;
				end
			end
			default: begin
				for (int i = 0; i < TAB_DEPTH; i++)
					shadow_tags[i] = TAG_EMPTY;
				shadow_bank  = 0;
				shadow_count = 0;
				shadow_size  = clear_size();
			end
		endcase
		r.key_total   = shadow_count[COUNT_W-1:0];
		r.size_in_use = shadow_size[COUNT_W-1:0];
		return r;
	endfunction

	// Send one request beat, with an occasional gap in front of it, and queue
	// the response it should produce once the beat has been taken.
	task automatic send_op(op_t op, logic [KEY_BITS-1:0] key);
		while (gaps_on && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid     <= 1'b1;
		req.operation <= op;
		req.key       <= key;
		do
			@(posedge clk);
		while (!req_ready);
		pending_rsp_q.push_back(table_outcome(op, key));
		beat_count++;
		if (op == OP_INSERT) begin
			key_pool.push_back(key);
			if (key_pool.size() > 64)
				void'(key_pool.pop_front());
		end
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Configuration beats go in only once every response has come back.
	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [INIT_SIZE_W-1:0] data);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == REG_INIT_SIZE)
			shadow_init_size = data;
		else if (index == REG_THRESHOLD)
			shadow_thr = data[THR_W-1:0];
	endtask

	task automatic set_table(logic [10:0] init_size, logic [10:0] thr);
		write_reg(REG_INIT_SIZE, init_size);
		write_reg(REG_THRESHOLD, thr);
		send_op(OP_CLEAR, $urandom() & KEY_MAX);
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready   <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_cycles <= 400;
			rsp_ready   <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_ready   <= 1'b0;
		end else begin
			rsp_ready <= !(gaps_on && $urandom_range(99) < 24);
		end
	end

	// Response checker: each beat is matched against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_count++;
			if (pending_rsp_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: response beat with nothing predicted: %p", $realtime, rsp);
			end else begin
				want = pending_rsp_q.pop_front();
				if (want.grew)
					grow_count++;
				if (want.status == STAT_FULL)
					full_count++;
				if (rsp.status !== want.status || rsp.slot !== want.slot ||
					rsp.key_total !== want.key_total ||
					rsp.size_in_use !== want.size_in_use || rsp.grew !== want.grew) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch, expected %p, got %p", $realtime, want, rsp);
				end
			end
		end
	end

	// Basic behaviour at the reset settings: misses on an empty table, the key
	// extremes, a duplicate, a tombstone in a probe chain, then a growth.
	task automatic test_basic_ops();
		send_op(OP_SEARCH, 31'd0);
		send_op(OP_DELETE, KEY_MAX);
		send_op(OP_INSERT, 31'd0);
		send_op(OP_INSERT, KEY_MAX);
		send_op(OP_INSERT, 31'd5);
		send_op(OP_SEARCH, 31'd5);
		send_op(OP_DELETE, 31'd0);
		send_op(OP_SEARCH, 31'd5);
		send_op(OP_SEARCH, 31'd0);
		send_op(OP_INSERT, 31'd10);
		send_op(OP_INSERT, 31'd10);
		send_op(OP_SEARCH, 31'd10);
		send_op(OP_DELETE, 31'd10);
		send_op(OP_SEARCH, 31'd10);
		send_op(OP_SEARCH, KEY_MAX);
		send_op(OP_CLEAR, 31'd0);
	endtask

	// A one-slot table that never grows: full inserts, reuse of a tombstone,
	// and register writes to unused indexes that must be ignored.
	task automatic test_full_table();
		set_table(11'd1, 11'd15);
		send_op(OP_INSERT, 31'h2AAA_AAAA);
		send_op(OP_INSERT, 31'h5555_5555);
		send_op(OP_SEARCH, 31'h2AAA_AAAA);
		send_op(OP_DELETE, 31'h2AAA_AAAA);
		send_op(OP_SEARCH, 31'h2AAA_AAAA);
		send_op(OP_INSERT, 31'h5555_5555);
		send_op(OP_INSERT, 31'd7);
		write_reg(REG_SPARE_A, 11'h7FF);
		write_reg(REG_SPARE_B, 11'h7FF);
		send_op(OP_CLEAR, KEY_MAX);
		send_op(OP_INSERT, 31'd3);
		send_op(OP_INSERT, 31'd4);
	endtask

	// Threshold zero from size one grows on every insert up to the cap; then a
	// clamped start at full capacity with a high threshold.
	task automatic test_growth_limits();
		set_table(11'd0, 11'd0);
		for (int i = 0; i < 12; i++)
			send_op(OP_INSERT, 31'(i * 37));
		send_op(OP_SEARCH, 31'd37);
		set_table(11'h7FF, 11'h7FA);
		send_op(OP_INSERT, 31'd1023);
		send_op(OP_INSERT, 31'd2047);
		send_op(OP_SEARCH, 31'd2047);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50 && key_pool.size() != 0)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		if (sel < 70)
			return 31'($urandom_range(63));
		if (sel < 85)
			return 31'($urandom_range(40) * shadow_size + $urandom_range(3));
		return $urandom() & KEY_MAX;
	endfunction

	function automatic op_t pick_op();
		int sel;
		sel = $urandom_range(99);
		if (sel < 46)
			return OP_INSERT;
		if (sel < 72)
			return OP_SEARCH;
		if (sel < 98)
			return OP_DELETE;
		return OP_CLEAR;
	endfunction

	task automatic random_burst(int count);
		for (int i = 0; i < count; i++)
			send_op(pick_op(), pick_key());
	endtask

	// Random traffic across several table settings, with a stretch without
	// gaps, a long receiver hold-off and a pause until everything has drained.
	task automatic test_random_traffic();
		set_table(11'd5, 11'd7);
		random_burst(120);
		set_table(11'd3, 11'd11);
		random_burst(100);
		set_table(11'd17, 11'd3);
		gaps_on = 1'b0;
		random_burst(120);
		gaps_on = 1'b1;
		set_table(11'd2, 11'd10);
		hold_request = 1'b1;
		random_burst(100);
		wait_for_drain();
		random_burst(60);
		set_table(11'd1024, 11'd7);
		random_burst(120);
		set_table(11'd300, 11'd1);
		random_burst(120);
		set_table(11'd1, 11'd0);
		random_burst(100);
	endtask

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		gaps_on      = 1'b1;
		hold_request = 1'b0;
		mismatch_count = 0;
		rsp_count    = 0;
		beat_count   = 0;
		grow_count   = 0;
		full_count   = 0;
		shadow_init_size = INIT_SIZE_RST;
		shadow_thr   = THR_RST;
		shadow_bank  = 0;
		shadow_count = 0;
		shadow_size  = int'(INIT_SIZE_RST);
		for (int i = 0; i < TAB_DEPTH; i++) begin
			shadow_tags[i] = TAG_EMPTY;
			shadow_keys[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_full_table();
		test_growth_limits();
		test_random_traffic();

		wait_for_drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d request beats and checked %0d responses.", beat_count, rsp_count);
		$display("Responses included %0d table growths and %0d full-table refusals.",
			grow_count, full_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### linear_probing_hash_table_core.f
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_mod_unit.sv
hw/rtl/lpht_slot_ram.sv
hw/rtl/linear_probing_hash_table_core.sv
bench/tb.sv
